>>> rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int REQ_W = 3;
    localparam int VAL_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4
    } bdq_req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } bdq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_FINISH
    } bdq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;
        logic        push;
        logic        read_end;
        logic        pop_commit;
        logic        scan_start;
        logic        scan_step;
        logic        set_status;
        bdq_status_t status_code;
        logic        set_found;
        logic        emit;
    } bdq_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             scan_hit;
        logic             scan_last;
    } bdq_stat_t;

    // Ring slot at base + offset, both below DEPTH.
    function automatic logic [IDX_W-1:0] slot_after(logic [IDX_W-1:0] base,
                                                    logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/bdq_if.sv
interface bdq_req_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::REQ_W-1:0]     req_type;
    logic signed [bdq_pkg::VAL_W-1:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink (input valid, input req_type, input item_value, output ready);
endinterface

interface bdq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bdq_pkg::STATUS_W-1:0]     status;
    logic                             found;
    logic signed [bdq_pkg::VAL_W-1:0] removed_value;
    logic [bdq_pkg::OCC_W-1:0]        occupancy;

    modport source (output valid, output status, output found, output removed_value,
                    output occupancy, input ready);
    modport sink (input valid, input status, input found, input removed_value,
                  input occupancy, output ready);
endinterface

>>> rtl/bounded_deque_with_search.sv
// Bounded double-ended queue of DEPTH signed 32-bit words kept in a ring buffer,
// taking one request at a time on req and answering each with exactly one word
// on rsp. A pop reads the end entry before it commits the removal, and a search
// on N held entries reads the entry memory through its single read port one
// entry per cycle and stops at the first match. A push into a full queue, a pop
// or search on an empty queue, and an unused request code are all answered from
// the EXEC state, with a full or empty status where one applies. A new request is
// accepted while the previous result still waits on rsp; its result is held until
// that word is taken.
module bounded_deque_with_search (
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    bdq_pkg::bdq_cmd_t  cmd;
    bdq_pkg::bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bdq_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_req_type       (req.req_type),
        .in_item_value     (req.item_value),
        .out_status        (rsp.status),
        .out_found         (rsp.found),
        .out_removed_value (rsp.removed_value),
        .out_occupancy     (rsp.occupancy)
    );

endmodule

>>> rtl/bdq_ctrl.sv
module bdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bdq_pkg::bdq_stat_t stat,
    output bdq_pkg::bdq_cmd_t  cmd
);

    bdq_pkg::bdq_state_t state_reg;
    bdq_pkg::bdq_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = bdq_pkg::ST_OK;
        in_ready        = 1'b0;

        case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdq_pkg::S_EXEC;
                end
            end
            bdq_pkg::S_EXEC:
            begin
                state_next = bdq_pkg::S_FINISH;
                case (stat.req)
                    bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.read_end = 1'b1;
                            state_next   = bdq_pkg::S_POP;
                        end
                    end
                    bdq_pkg::REQ_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = bdq_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = bdq_pkg::S_FINISH;
                    end
                endcase
            end
            bdq_pkg::S_POP:
            begin
                cmd.pop_commit = 1'b1;
                state_next     = bdq_pkg::S_FINISH;
            end
            bdq_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = bdq_pkg::S_FINISH;
                end
                else if (stat.scan_last)
                begin
                    state_next = bdq_pkg::S_FINISH;
                end
            end
            bdq_pkg::S_FINISH:
            begin
                // Hold the finished result until the output register is free.
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase

        out_valid_next = cmd.emit || (out_valid_reg && !out_ready);
    end

endmodule

>>> rtl/bdq_dp.sv
module bdq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdq_pkg::bdq_cmd_t                   cmd,
    output bdq_pkg::bdq_stat_t                  stat,
    input  logic [bdq_pkg::REQ_W-1:0]           in_req_type,
    input  logic signed [bdq_pkg::VAL_W-1:0]    in_item_value,
    output logic [bdq_pkg::STATUS_W-1:0]        out_status,
    output logic                                out_found,
    output logic signed [bdq_pkg::VAL_W-1:0]    out_removed_value,
    output logic [bdq_pkg::OCC_W-1:0]           out_occupancy
);

    logic [bdq_pkg::VAL_W-1:0] mem [bdq_pkg::DEPTH];

    logic [bdq_pkg::IDX_W-1:0]    front_reg, front_next;
    logic [bdq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [bdq_pkg::CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic                         cmp_last_reg, cmp_last_next;
    logic [bdq_pkg::REQ_W-1:0]    req_reg, req_next;
    logic [bdq_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [bdq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         res_found_reg, res_found_next;
    logic [bdq_pkg::VAL_W-1:0]    res_removed_reg, res_removed_next;
    logic [bdq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                         out_found_reg, out_found_next;
    logic [bdq_pkg::VAL_W-1:0]    out_removed_reg, out_removed_next;
    logic [bdq_pkg::OCC_W-1:0]    out_occ_reg, out_occ_next;
    logic [bdq_pkg::VAL_W-1:0]    rd_data_reg;

    logic                         is_front;
    logic                         full;
    logic                         empty;
    logic                         scan_issue;
    logic [bdq_pkg::IDX_W-1:0]    front_dec;
    logic [bdq_pkg::IDX_W-1:0]    front_inc;
    logic [bdq_pkg::IDX_W-1:0]    back_slot;
    logic [bdq_pkg::IDX_W-1:0]    last_slot;
    logic [bdq_pkg::IDX_W-1:0]    scan_slot;
    logic [bdq_pkg::IDX_W-1:0]    wr_addr;
    logic [bdq_pkg::IDX_W-1:0]    rd_addr;

    assign is_front = (req_reg == bdq_pkg::REQ_PUSH_FRONT)
                   || (req_reg == bdq_pkg::REQ_POP_FRONT);
    assign full  = (count_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = bdq_pkg::slot_after(front_reg, bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1));
    assign front_inc = bdq_pkg::slot_after(front_reg, bdq_pkg::IDX_W'(1));
    assign back_slot = bdq_pkg::slot_after(front_reg, count_reg[bdq_pkg::IDX_W-1:0]);
    assign last_slot = bdq_pkg::slot_after(front_reg,
                                           bdq_pkg::IDX_W'(count_reg - 1'b1));
    assign scan_slot = bdq_pkg::slot_after(front_reg, issue_idx_reg[bdq_pkg::IDX_W-1:0]);

    assign wr_addr = is_front ? front_dec : back_slot;
    assign rd_addr = cmd.read_end ? (is_front ? front_reg : last_slot) : scan_slot;

    assign scan_issue = cmd.scan_step && (issue_idx_reg < count_reg);

    // The compare runs in the cycle after the read it checks, on the registered read data.
    assign stat.req       = req_reg;
    assign stat.full      = full;
    assign stat.empty     = empty;
    assign stat.scan_hit  = cmp_valid_reg && (rd_data_reg == val_reg);
    assign stat.scan_last = cmp_valid_reg && cmp_last_reg;

    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        issue_idx_next   = issue_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_last_next    = cmp_last_reg;
        req_next         = req_reg;
        val_next         = val_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_removed_next = out_removed_reg;
        out_occ_next     = out_occ_reg;

        if (cmd.load)
        begin
            req_next         = in_req_type;
            val_next         = in_item_value;
            res_status_next  = bdq_pkg::ST_OK;
            res_found_next   = 1'b0;
            res_removed_next = '0;
        end

        if (cmd.set_status)
        begin
            res_status_next = cmd.status_code;
        end

        if (cmd.push)
        begin
            if (is_front)
            begin
                front_next = front_dec;
            end
            count_next = count_reg + 1'b1;
        end

        if (cmd.pop_commit)
        begin
            res_removed_next = rd_data_reg;
            if (is_front)
            begin
                front_next = front_inc;
            end
            count_next = count_reg - 1'b1;
        end

        if (cmd.scan_start)
        begin
            issue_idx_next = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            cmp_valid_next = scan_issue;
            cmp_last_next  = (issue_idx_reg == count_reg - 1'b1);
            if (scan_issue)
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
            end
        end
        else
        begin
            cmp_valid_next = 1'b0;
        end

        if (cmd.set_found)
        begin
            res_found_next = 1'b1;
        end

        if (cmd.emit)
        begin
            out_status_next  = res_status_reg;
            out_found_next   = res_found_reg;
            out_removed_next = res_removed_reg;
            out_occ_next     = bdq_pkg::OCC_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg   <= issue_idx_next;
        cmp_last_reg    <= cmp_last_next;
        req_reg         <= req_next;
        val_reg         <= val_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_removed_reg <= out_removed_next;
        out_occ_reg     <= out_occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign out_status        = out_status_reg;
    assign out_found         = out_found_reg;
    assign out_removed_value = out_removed_reg;
    assign out_occupancy     = out_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the queue by one");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_commit |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shrink the queue by one");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !full)
        else $error("push issued into a full queue");

endmodule

>>> verif/bounded_deque_with_search_checker.sv
`timescale 1ns / 1ps

module bounded_deque_with_search_checker (
    input  logic clk,
    input  logic rst_n,
    bdq_req_if   req_mon,
    bdq_rsp_if   rsp_mon,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   full_seen,
    output int   empty_seen,
    output int   found_seen
);

    typedef struct packed {
        bdq_pkg::bdq_status_t             status;
        logic                             found;
        logic signed [bdq_pkg::VAL_W-1:0] removed;
        logic [bdq_pkg::OCC_W-1:0]        occ;
    } deque_answer_t;

    // Shadow copy of the ring: slot contents, front slot and number of held words.
    logic signed [bdq_pkg::VAL_W-1:0] ring [bdq_pkg::DEPTH];
    int                               head;
    int                               held;
    deque_answer_t                    answer_q [$];
    deque_answer_t                    want;

    function automatic int ring_slot(int offset);
        return (head + offset) % bdq_pkg::DEPTH;
    endfunction

    function automatic deque_answer_t apply_request(logic [bdq_pkg::REQ_W-1:0] kind,
                                                    logic signed [bdq_pkg::VAL_W-1:0] value);
        deque_answer_t a;
        a = '{bdq_pkg::ST_OK, 1'b0, '0, '0};
        case (kind)
            bdq_pkg::REQ_PUSH_FRONT:
            begin
                if (held >= bdq_pkg::DEPTH)
                begin
                    a.status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    head = (head + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
                    ring[head] = value;
                    held++;
                end
            end
            bdq_pkg::REQ_PUSH_BACK:
            begin
                if (held >= bdq_pkg::DEPTH)
                begin
                    a.status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    ring[ring_slot(held)] = value;
                    held++;
                end
            end
            bdq_pkg::REQ_POP_FRONT:
            begin
                if (held == 0)
                begin
                    a.status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    a.removed = ring[head];
                    head = ring_slot(1);
                    held--;
                end
            end
            bdq_pkg::REQ_POP_BACK:
            begin
                if (held == 0)
                begin
                    a.status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    a.removed = ring[ring_slot(held - 1)];
                    held--;
                end
            end
            bdq_pkg::REQ_SEARCH:
            begin
                if (held == 0)
                begin
                    a.status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        if (ring[ring_slot(i)] == value)
                        begin
                            a.found = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // Unused request codes leave the queue alone.
            end
        endcase
        a.occ = bdq_pkg::OCC_W'(held);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            held = 0;
            answer_q.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
            full_seen = 0;
            empty_seen = 0;
            found_seen = 0;
        end
        else
        begin
            // A result word always belongs to an earlier request, so it is
            // matched before a request taken at the same edge is predicted.
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result word with no request waiting: status %0d occupancy %0d",
                           rsp_mon.status, rsp_mon.occupancy);
                    fail_count++;
                end
                else
                begin
                    want = answer_q[0];
                    answer_q.delete(0);
                    checked++;
                    if (rsp_mon.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                        fail_count++;
                    end
                    if (rsp_mon.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp_mon.found);
                        fail_count++;
                    end
                    if (rsp_mon.removed_value !== want.removed)
                    begin
                        $error("removed_value: expected %0d, got %0d",
                               $signed(want.removed), $signed(rsp_mon.removed_value));
                        fail_count++;
                    end
                    if (rsp_mon.occupancy !== want.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occ, rsp_mon.occupancy);
                        fail_count++;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
            begin
                want = apply_request(req_mon.req_type, req_mon.item_value);
                if (want.status == bdq_pkg::ST_FULL)
                begin
                    full_seen++;
                end
                if (want.status == bdq_pkg::ST_EMPTY)
                begin
                    empty_seen++;
                end
                if (want.found)
                begin
                    found_seen++;
                end
                answer_q = {answer_q, want};
            end
            pending = answer_q.size();
        end
    end

endmodule

>>> verif/bounded_deque_with_search_tb.sv
`timescale 1ns / 1ps

module bounded_deque_with_search_tb;

    localparam int ITEM_TOTAL = 1050;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_WAIT = 16;
    localparam logic [bdq_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [bdq_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam logic signed [bdq_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [bdq_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int found_seen;

    int cycles = 0;
    int sent = 0;
    int sent_push = 0;
    int sent_pop = 0;
    int sent_search = 0;
    int sent_unused = 0;
    int quiet_pauses = 0;
    bit no_idle;
    logic signed [bdq_pkg::VAL_W-1:0] pool [8];

    int stall;
    int phase_kind;
    int phase_len;
    int push_pct;
    int roll;
    logic [bdq_pkg::REQ_W-1:0] kind;

    bounded_deque_with_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bounded_deque_with_search_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_seen  (full_seen),
        .empty_seen (empty_seen),
        .found_seen (found_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random wait one side takes before its next word; a burst phase skips the wait.
    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic signed [bdq_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
        begin
            return pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    task automatic send_word(input logic [bdq_pkg::REQ_W-1:0] code,
                             input logic signed [bdq_pkg::VAL_W-1:0] value);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= code;
        req_ch.item_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
        case (code)
            bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: sent_push++;
            bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK:   sent_pop++;
            bdq_pkg::REQ_SEARCH:                             sent_search++;
            default:                                         sent_unused++;
        endcase
    endtask

    // Drops valid and holds off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            repeat (stall)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.req_type = bdq_pkg::REQ_PUSH_FRONT;
        req_ch.item_value = '0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        foreach (pool[i])
        begin
            pool[i] = $urandom;
        end
        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty queue: pops and search are flagged, unused codes change nothing.
        send_word(bdq_pkg::REQ_POP_FRONT, VAL_MAX);
        send_word(bdq_pkg::REQ_POP_BACK, VAL_MIN);
        send_word(bdq_pkg::REQ_SEARCH, '0);
        send_word(REQ_UNUSED_LO, '1);
        // A single held word popped from either end empties the queue again.
        send_word(bdq_pkg::REQ_PUSH_BACK, VAL_MAX);
        send_word(bdq_pkg::REQ_POP_FRONT, '0);
        send_word(bdq_pkg::REQ_PUSH_FRONT, VAL_MIN);
        send_word(bdq_pkg::REQ_POP_BACK, '0);
        send_word(bdq_pkg::REQ_PUSH_FRONT, -32'sd1);
        send_word(bdq_pkg::REQ_PUSH_BACK, '0);
        send_word(bdq_pkg::REQ_SEARCH, -32'sd1);
        send_word(bdq_pkg::REQ_SEARCH, 32'sd1);
        // Fill to the brim from both ends, then try to push past it.
        for (int i = 0; i < bdq_pkg::DEPTH - 2; i++)
        begin
            send_word(i[0] ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT, pick_value());
        end
        send_word(bdq_pkg::REQ_PUSH_FRONT, VAL_MAX);
        send_word(bdq_pkg::REQ_PUSH_BACK, VAL_MIN);
        send_word(bdq_pkg::REQ_SEARCH, '0);
        send_word(REQ_UNUSED_HI, VAL_MIN);

        // Phases lean toward filling, draining or a balance, so the queue
        // keeps swinging between full and empty.
        while (sent < ITEM_TOTAL)
        begin
            phase_kind = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 60);
            no_idle = ($urandom_range(0, 3) == 0);
            push_pct = (phase_kind == 0) ? 75 : (phase_kind == 1) ? 20 : 45;
            foreach (pool[i])
            begin
                case ($urandom_range(0, 9))
                    0:       pool[i] = VAL_MIN;
                    1:       pool[i] = VAL_MAX;
                    2:       pool[i] = '0;
                    3:       pool[i] = -32'sd1;
                    default: pool[i] = $urandom;
                endcase
            end
            if (quiet_pauses == 0 || $urandom_range(0, 7) == 0)
            begin
                drain_results();
                quiet_pauses++;
            end
            for (int n = 0; n < phase_len && sent < ITEM_TOTAL; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    kind = bdq_pkg::REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                end
                else if (roll < 23)
                begin
                    kind = bdq_pkg::REQ_SEARCH;
                end
                else if (roll < 23 + (push_pct * 77) / 100)
                begin
                    kind = $urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_BACK
                                                : bdq_pkg::REQ_PUSH_FRONT;
                end
                else
                begin
                    kind = $urandom_range(0, 1) ? bdq_pkg::REQ_POP_BACK
                                                : bdq_pkg::REQ_POP_FRONT;
                end
                send_word(kind, ($urandom_range(0, 7) == 0) ? $urandom : pick_value());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        $display("Sent %0d requests: %0d pushes, %0d pops, %0d searches, %0d unused codes.",
                 sent, sent_push, sent_pop, sent_search, sent_unused);
        $display("Checked %0d results: %0d full refusals, %0d empty, %0d search hits, %0d pauses.",
                 checked, full_seen, empty_seen, found_seen, quiet_pauses);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_ctrl.sv
rtl/bdq_dp.sv
rtl/bounded_deque_with_search.sv
verif/bounded_deque_with_search_checker.sv
verif/bounded_deque_with_search_tb.sv
